// ----- rtl/core/sorted_priority_queue_top_defines.svh -----
// ---------------------------------------------------------------------------
// Sorted priority queue assertion macros
// Shared concurrent assertion forms for the queue checker.
// ---------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_TOP_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define SPQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define SPQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/spq_pkg.sv -----
// ---------------------------------------------------------------------------
// Sorted priority queue package
// Request, response and entry types shared by the queue modules.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package spq_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int DATA_W       = 32;
    localparam int COUNT_W      = 5;

    typedef enum logic {
        FUNC_ENQUEUE = 1'b0,
        FUNC_DEQUEUE = 1'b1
    } func_t;

    typedef struct packed {
        func_t                     func;
        logic signed [DATA_W-1:0]  value;
        logic signed [DATA_W-1:0]  priority_req;
    } req_t;

    typedef struct packed {
        logic signed [DATA_W-1:0]  head_value;
        logic signed [DATA_W-1:0]  head_priority;
        logic                      is_empty;
        logic        [COUNT_W-1:0] entry_count;
        logic                      overflow;
        logic                      underflow;
    } rsp_t;

    typedef struct packed {
        logic signed [DATA_W-1:0]  value;
        logic signed [DATA_W-1:0]  prio;
    } entry_t;

    typedef struct packed {
        logic enq;
        logic deq;
    } cell_ctrl_t;

endpackage

// ----- rtl/core/spq_cell.sv -----
// ---------------------------------------------------------------------------
// Sorted priority queue cell
// One slot of the sorted row: keeps, takes the new entry, or shifts.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module spq_cell (
    input  logic                clk,
    input  spq_pkg::cell_ctrl_t ctrl,
    input  spq_pkg::entry_t     new_entry,
    input  spq_pkg::entry_t     left_entry,
    input  spq_pkg::entry_t     right_entry,
    input  logic                left_keep,
    input  logic                occupied,
    output spq_pkg::entry_t     entry,
    output logic                keep
);
    import spq_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;

    // Equal priorities stay ahead of the newcomer, so arrival order holds.
    assign keep  = occupied && ($signed(entry_reg.prio) <= $signed(new_entry.prio));
    assign entry = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.enq && !keep)
        begin
            entry_next = left_keep ? new_entry : left_entry;
        end
        else if (ctrl.deq)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

// ----- rtl/core/sorted_priority_queue_top.sv -----
// ---------------------------------------------------------------------------
// Sorted priority queue
// Shift-on-insert priority queue built from a row of entry cells.
// ---------------------------------------------------------------------------
// Every request (enqueue or dequeue) takes one cycle and yields one
// response: done pulses for a single cycle right after the accepting edge
// and the response must be taken then. busy stays low, so a new request
// may be issued every cycle. All cells compare the new priority against
// their own in parallel and shift in the same cycle, so the update of the
// whole row settles in one cycle for any CAPACITY. Ties leave in arrival
// order; an enqueue into a full queue or a dequeue from an empty one
// changes nothing and raises overflow or underflow.
`timescale 1ns / 1ps

module sorted_priority_queue_top #(
    parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  spq_pkg::req_t req,
    output logic          done,
    output spq_pkg::rsp_t rsp
);
    import spq_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             done_reg;
    logic             overflow_reg;
    logic             underflow_reg;

    logic       accept;
    logic       full;
    logic       empty;
    logic       is_enq;
    logic       ovf_next;
    logic       unf_next;
    cell_ctrl_t ctrl;
    entry_t     new_entry;

    entry_t cell_entry [CAPACITY];
    logic   cell_keep  [CAPACITY];

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign full   = (count_reg == CNT_W'(CAPACITY));
    assign empty  = (count_reg == '0);
    assign is_enq = (req.func == FUNC_ENQUEUE);

    assign ctrl.enq = accept && is_enq && !full;
    assign ctrl.deq = accept && !is_enq && !empty;
    assign ovf_next = accept && is_enq && full;
    assign unf_next = accept && !is_enq && empty;

    assign new_entry.value = req.value;
    assign new_entry.prio  = req.priority_req;

    always_comb
    begin
        count_next = count_reg;
        if (ctrl.enq)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (ctrl.deq)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        entry_t left_e;
        entry_t right_e;
        logic   left_k;

        if (i == 0)
        begin : g_first
            assign left_e = new_entry;
            assign left_k = 1'b1;
        end
        else
        begin : g_inner
            assign left_e = cell_entry[i-1];
            assign left_k = cell_keep[i-1];
        end

        // Last cell holds its own entry on dequeue; it is beyond count anyway.
        if (i == CAPACITY - 1)
        begin : g_last
            assign right_e = cell_entry[i];
        end
        else
        begin : g_mid
            assign right_e = cell_entry[i+1];
        end

        spq_cell u_cell (
            .clk         (clk),
            .ctrl        (ctrl),
            .new_entry   (new_entry),
            .left_entry  (left_e),
            .right_entry (right_e),
            .left_keep   (left_k),
            .occupied    (CNT_W'(i) < count_reg),
            .entry       (cell_entry[i]),
            .keep        (cell_keep[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        overflow_reg  <= ovf_next;
        underflow_reg <= unf_next;
    end

    // Response reads the row after the update, alongside done.
    assign done              = done_reg;
    assign rsp.head_value    = empty ? '0 : cell_entry[0].value;
    assign rsp.head_priority = empty ? '0 : cell_entry[0].prio;
    assign rsp.is_empty      = empty;
    assign rsp.entry_count   = COUNT_W'(count_reg);
    assign rsp.overflow      = overflow_reg;
    assign rsp.underflow     = underflow_reg;

endmodule

// ----- rtl/core/spq_checker.sv -----
// ---------------------------------------------------------------------------
// Sorted priority queue checker
// Port-level assertions on request and response timing and flags.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sorted_priority_queue_top_defines.svh"

module spq_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          start,
    input logic          busy,
    input logic          done,
    input spq_pkg::rsp_t rsp
);
    import spq_pkg::*;

    logic req_taken;
    logic head_clear;

    assign req_taken  = start && !busy;
    assign head_clear = (rsp.head_value == '0) && (rsp.head_priority == '0) &&
                        (rsp.entry_count == '0);

    `SPQ_ASSERT_NEXT(a_done_after_req, req_taken, done, "request without response")
    `SPQ_ASSERT_NEXT(a_no_spurious_done, !req_taken, !done, "response without request")
    `SPQ_ASSERT_NOW(a_empty_head_zero, done && rsp.is_empty, head_clear, "empty queue reports a head")
    `SPQ_ASSERT_NOW(a_flags_exclusive, done, !(rsp.overflow && rsp.underflow), "overflow and underflow together")
    `SPQ_ASSERT_NOW(a_underflow_empty, done && rsp.underflow, rsp.is_empty, "underflow on a non-empty queue")

endmodule

bind sorted_priority_queue_top spq_checker u_spq_checker (.*);
